// ===== rtl/hold_and_modify_pixel_decoder_defines.svh =====
// Assertion macros shared by the decoder's checker.
`ifndef HOLD_AND_MODIFY_PIXEL_DECODER_DEFINES_SVH
`define HOLD_AND_MODIFY_PIXEL_DECODER_DEFINES_SVH

// Property checked only out of reset.
`define HAMD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property checked at every edge, reset included.
`define HAMD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/hamd_pkg.sv =====
// Types, codes and constants of the hold-and-modify pixel decoder.
`timescale 1ns / 1ps
package hamd_pkg;

    localparam int TABLE_DEPTH_DEF = 256;

    // Half-brightness region of the palette
    localparam int EHB_BASE = 32;
    localparam int EHB_SIZE = 32;
    localparam int EHB_END  = 64;

    // Result queue depth
    localparam int OUT_DEPTH = 4;

    localparam logic [1:0] MODE_INDEXED = 2'd0;
    localparam logic [1:0] MODE_HAM6    = 2'd1;
    localparam logic [1:0] MODE_HAM8    = 2'd2;

    localparam logic CFG_COLOR_MODE = 1'b0;
    localparam logic CFG_EHB_ENABLE = 1'b1;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam logic [1:0] HAM_LOAD  = 2'd0;
    localparam logic [1:0] HAM_BLUE  = 2'd1;
    localparam logic [1:0] HAM_RED   = 2'd2;
    localparam logic [1:0] HAM_GREEN = 2'd3;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    typedef struct packed {
        logic       en;
        logic [7:0] idx;
        rgb_t       rgb;
    } pal_wr_t;

    typedef struct packed {
        logic       en;
        logic [7:0] addr;
    } pal_rd_t;

    function automatic rgb_t half_rgb(input rgb_t c);
        rgb_t h;
        h.r = {1'b0, c.r[7:1]};
        h.g = {1'b0, c.g[7:1]};
        h.b = {1'b0, c.b[7:1]};
        return h;
    endfunction

endpackage

// ===== rtl/hold_and_modify_pixel_decoder.sv =====
// An accepted pixel is registered by the palette read, then queued for m_tdata.
// Throughput: one item per cycle when not stalled, palette writes included;
// the half-brite copy goes to its own bank in the same cycle, so the palette
// port never stalls. s_tready drops while queued results plus the pixel in
// decode reach four. Reset clears the palette valid flags, held colour and
// registers; no clearing pass, the block accepts items right after reset.
`timescale 1ns / 1ps
module hold_and_modify_pixel_decoder import hamd_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // pixel_code[7:0], entry_index[15:8], red_in[23:16], green_in[31:24],
    // blue_in[39:32]
    input  logic [39:0] s_tdata,
    // req_type[0], frame_start[1]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // red_out[7:0], green_out[15:8], blue_out[23:16]
    output logic [23:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [1:0]  cfg_data
);

    localparam int CNT_W = $clog2(OUT_DEPTH + 1);

    logic [1:0] color_mode_reg;
    logic       ehb_enable_reg;

    logic       accept;
    logic [7:0] pixel_code;
    pal_wr_t    pal_wr;
    pal_rd_t    pal_rd;
    rgb_t       tbl_color;

    logic       pix_valid_reg;
    logic [7:0] pix_code_reg;
    logic       pix_fs_reg;
    rgb_t       pix_color;

    rgb_t             out_color;
    logic [CNT_W-1:0] q_count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_mode_reg <= MODE_INDEXED;
            ehb_enable_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_COLOR_MODE: color_mode_reg <= cfg_data;
                CFG_EHB_ENABLE: ehb_enable_reg <= cfg_data[0];
            endcase
        end
    end

    // Room for the item in the decode stage and every queued result
    assign s_tready = (q_count + CNT_W'(pix_valid_reg)) < CNT_W'(OUT_DEPTH);
    assign accept   = s_tvalid && s_tready;
    assign pixel_code = s_tdata[7:0];

    always_comb begin
        pal_wr.en    = accept && (s_tuser[0] == REQ_WRITE);
        pal_wr.idx   = s_tdata[15:8];
        pal_wr.rgb.r = s_tdata[23:16];
        pal_wr.rgb.g = s_tdata[31:24];
        pal_wr.rgb.b = s_tdata[39:32];

        pal_rd.en = accept && (s_tuser[0] == REQ_PIXEL);
        unique case (color_mode_reg)
            MODE_HAM6: pal_rd.addr = {4'b0, pixel_code[3:0]};
            MODE_HAM8: pal_rd.addr = {2'b0, pixel_code[5:0]};
            default:   pal_rd.addr = pixel_code;
        endcase
    end

    hamd_palette #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_palette (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ehb_enable (ehb_enable_reg),
        .wr         (pal_wr),
        .rd         (pal_rd),
        .rd_color   (tbl_color)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix_valid_reg <= 1'b0;
        end else begin
            pix_valid_reg <= pal_rd.en;
        end
    end

    always_ff @(posedge aclk) begin
        if (pal_rd.en) begin
            pix_code_reg <= pixel_code;
            pix_fs_reg   <= s_tuser[1];
        end
    end

    hamd_update u_update (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .color_mode (color_mode_reg),
        .pix_valid  (pix_valid_reg),
        .pix_code   (pix_code_reg),
        .pix_fs     (pix_fs_reg),
        .tbl_color  (tbl_color),
        .pix_color  (pix_color)
    );

    hamd_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (pix_valid_reg),
        .push_data (pix_color),
        .pop_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (out_color),
        .count     (q_count)
    );

    assign m_tdata = {out_color.b, out_color.g, out_color.r};

endmodule

// ===== rtl/hamd_palette.sv =====
// Palette memory: main bank plus a 32-entry bank for the half-brightness region.
`timescale 1ns / 1ps
module hamd_palette import hamd_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    ehb_enable,
    input  pal_wr_t wr,
    input  pal_rd_t rd,
    output rgb_t    rd_color
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int BANK_W = $clog2(EHB_SIZE);

    rgb_t mem_a [TABLE_DEPTH];
    rgb_t mem_b [EHB_SIZE];

    logic [TABLE_DEPTH-1:0] vld_a_reg;
    logic [EHB_SIZE-1:0]    vld_b_reg;

    rgb_t a_q_reg;
    rgb_t b_q_reg;
    logic a_ok_reg;
    logic b_ok_reg;

    logic              wr_in_range;
    logic              wr_low;
    logic              wr_ehb;
    logic              we_a;
    logic              we_b;
    rgb_t              wb_data;
    logic [IDX_W-1:0]  wa_idx;
    logic [BANK_W-1:0] wb_idx;

    logic              rd_in_range;
    logic              rd_sel_b;
    logic [IDX_W-1:0]  ra_idx;
    logic [BANK_W-1:0] rb_idx;

    always_comb begin
        wr_in_range = {1'b0, wr.idx} < 9'(TABLE_DEPTH);
        wr_low      = wr.idx < 8'(EHB_BASE);
        wr_ehb      = (wr.idx >= 8'(EHB_BASE)) && (wr.idx < 8'(EHB_END));
        // With half-brite on, low writes also fill the derived bank and
        // direct writes to the derived region are dropped.
        we_a        = wr.en && wr_in_range && !wr_ehb;
        we_b        = wr.en && wr_in_range && (ehb_enable ? wr_low : wr_ehb);
        wb_data     = ehb_enable ? half_rgb(wr.rgb) : wr.rgb;
        wa_idx      = wr.idx[IDX_W-1:0];
        wb_idx      = wr.idx[BANK_W-1:0];

        rd_in_range = {1'b0, rd.addr} < 9'(TABLE_DEPTH);
        rd_sel_b    = (rd.addr >= 8'(EHB_BASE)) && (rd.addr < 8'(EHB_END));
        ra_idx      = rd.addr[IDX_W-1:0];
        rb_idx      = rd.addr[BANK_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_a_reg <= '0;
            vld_b_reg <= '0;
        end else begin
            if (we_a) begin
                vld_a_reg[wa_idx] <= 1'b1;
            end
            if (we_b) begin
                vld_b_reg[wb_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (we_a) begin
            mem_a[wa_idx] <= wr.rgb;
        end
        if (we_b) begin
            mem_b[wb_idx] <= wb_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.en) begin
            a_q_reg  <= mem_a[ra_idx];
            b_q_reg  <= mem_b[rb_idx];
            a_ok_reg <= rd_in_range && !rd_sel_b && vld_a_reg[ra_idx];
            b_ok_reg <= rd_in_range && rd_sel_b && vld_b_reg[rb_idx];
        end
    end

    // Entries never written read as zero, as does an index past the table.
    always_comb begin
        if (a_ok_reg) begin
            rd_color = a_q_reg;
        end else if (b_ok_reg) begin
            rd_color = b_q_reg;
        end else begin
            rd_color = '0;
        end
    end

endmodule

// ===== rtl/hamd_update.sv =====
// Held colour register and the hold-and-modify update of one pixel.
`timescale 1ns / 1ps
module hamd_update import hamd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] color_mode,
    input  logic       pix_valid,
    input  logic [7:0] pix_code,
    input  logic       pix_fs,
    input  rgb_t       tbl_color,
    output rgb_t       pix_color
);

    rgb_t       held_reg;
    rgb_t       held_next;
    rgb_t       base;
    logic       ham_mode;
    logic       ham_on;
    logic [1:0] action;
    logic [7:0] wide;

    always_comb begin
        base = pix_fs ? '0 : held_reg;
        unique case (color_mode)
            MODE_HAM6: begin
                ham_mode = 1'b1;
                // codes above 63 keep the held colour
                ham_on   = (pix_code[7:6] == 2'b00);
                action   = pix_code[5:4];
                wide     = {pix_code[3:0], pix_code[3:0]};
            end
            MODE_HAM8: begin
                ham_mode = 1'b1;
                ham_on   = 1'b1;
                action   = pix_code[7:6];
                wide     = {pix_code[5:0], pix_code[5:4]};
            end
            default: begin
                ham_mode = 1'b0;
                ham_on   = 1'b0;
                action   = HAM_LOAD;
                wide     = '0;
            end
        endcase

        held_next = base;
        if (ham_mode && ham_on) begin
            case (action)
                HAM_LOAD:  held_next   = tbl_color;
                HAM_BLUE:  held_next.b = wide;
                HAM_RED:   held_next.r = wide;
                HAM_GREEN: held_next.g = wide;
                default:   held_next   = base;
            endcase
        end
        pix_color = ham_mode ? held_next : tbl_color;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
        end else if (pix_valid) begin
            held_reg <= held_next;
        end
    end

endmodule

// ===== rtl/hamd_out_fifo.sv =====
// Small result queue between the decode stage and the output port.
`timescale 1ns / 1ps
module hamd_out_fifo import hamd_pkg::*; (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           push,
    input  rgb_t                           push_data,
    input  logic                           pop_ready,
    output logic                           out_valid,
    output rgb_t                           out_data,
    output logic [$clog2(OUT_DEPTH+1)-1:0] count
);

    localparam int PTR_W = $clog2(OUT_DEPTH);
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);

    rgb_t             slot_reg [OUT_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             pop;

    assign out_valid = (cnt_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign count     = cnt_reg;
    assign pop       = out_valid && pop_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/hamd_checker.sv =====
// Port-level checks on the decoder, bound to the top level.
`timescale 1ns / 1ps
`include "hold_and_modify_pixel_decoder_defines.svh"
module hamd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    `HAMD_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
    `HAMD_ASSERT(a_out_stable, m_tvalid && !m_tready |=> $stable(m_tdata), "result changed while stalled")
    `HAMD_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "result pending after reset")
    // A new result must come from an accepted pixel item, not a palette write
    `HAMD_ASSERT(a_out_source, $rose(m_tvalid) |-> $past(s_tvalid && s_tready && !s_tuser[0], 2), "result without pixel")

endmodule

bind hold_and_modify_pixel_decoder hamd_checker u_hamd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== sim/tb_hold_and_modify_pixel_decoder.sv =====
// Self-checking testbench for the hold-and-modify pixel decoder.
`timescale 1ns / 1ps
import hamd_pkg::*;

// Tracks palette, held colour and registers; keeps the colours still owed by the block.
class rgb_scoreboard;
    rgb_t palette [TABLE_DEPTH_DEF];
    rgb_t held;
    logic [1:0] mode;
    logic ehb;
    rgb_t expected_pixels [$];
    int mismatches;

    function new();
        foreach (palette[i]) palette[i] = '0;
        held = '0;
        mode = MODE_INDEXED;
        ehb = 1'b0;
        mismatches = 0;
    endfunction

    function int pending();
        return expected_pixels.size();
    endfunction

    function void write_reg(logic index, logic [1:0] value);
        if (index == CFG_COLOR_MODE) begin
            mode = value;
        end else begin
            ehb = value[0];
        end
    endfunction

    function void store_entry(logic [7:0] idx, rgb_t c);
        if (ehb) begin
            if (idx >= EHB_BASE && idx < EHB_END) return;
            if (idx < EHB_BASE) palette[idx + EHB_SIZE] = rgb_t'{c.r >> 1, c.g >> 1, c.b >> 1};
        end
        palette[idx] = c;
    endfunction

    function void modify_held(logic [7:0] code, bit wide_data);
        logic [7:0] data;
        logic [7:0] widened;
        int action;
        if (wide_data) begin
            data = {2'b00, code[5:0]};
            widened = {code[5:0], code[5:4]};
            action = code[7:6];
        end else begin
            data = {4'h0, code[3:0]};
            widened = {code[3:0], code[3:0]};
            action = code[7:4];
        end
        case (action)
            HAM_LOAD:  held = palette[data];
            HAM_BLUE:  held.b = widened;
            HAM_RED:   held.r = widened;
            HAM_GREEN: held.g = widened;
            default: ;  // HAM6 codes above 63 keep the held colour
        endcase
    endfunction

    function void note_request(logic req, logic [7:0] code, logic [7:0] idx, rgb_t c,
                               logic frame_start);
        if (req == REQ_WRITE) begin
            store_entry(idx, c);
            return;
        end
        if (frame_start) held = '0;
        case (mode)
            MODE_HAM6: begin
                modify_held(code, 1'b0);
                expected_pixels.push_back(held);
            end
            MODE_HAM8: begin
                modify_held(code, 1'b1);
                expected_pixels.push_back(held);
            end
            default: expected_pixels.push_back(palette[code]);
        endcase
    endfunction

    task report(string what);
        $display("ERROR at %0t: %s", $time, what);
        mismatches++;
    endtask

    task check_pixel(logic [23:0] tdata);
        rgb_t got;
        rgb_t want;
        got = rgb_t'{tdata[7:0], tdata[15:8], tdata[23:16]};
        if (expected_pixels.size() == 0) begin
            report($sformatf("unexpected pixel %06h", got));
            return;
        end
        want = expected_pixels.pop_front();
        if (got.r !== want.r) report($sformatf("red got %02h want %02h", got.r, want.r));
        if (got.g !== want.g) report($sformatf("green got %02h want %02h", got.g, want.g));
        if (got.b !== want.b) report($sformatf("blue got %02h want %02h", got.b, want.b));
    endtask
endclass

module tb_hold_and_modify_pixel_decoder;

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEMS_PER_SEGMENT = 64;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [1:0]  cfg_data;

    rgb_scoreboard board = new();
    int send_idle_pct;
    int recv_idle_pct;
    int cycles = 0;
    logic [1:0] cur_mode;

    hold_and_modify_pixel_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Inputs are noted before outputs are checked at the same edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready) begin
                board.note_request(s_tuser[0], s_tdata[7:0], s_tdata[15:8],
                                   rgb_t'{s_tdata[23:16], s_tdata[31:24], s_tdata[39:32]},
                                   s_tuser[1]);
            end
            if (m_tvalid && m_tready) board.check_pixel(m_tdata);
        end
    end

    task send_item(logic req, logic [7:0] code, logic [7:0] idx, rgb_t c, logic fs);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {c.b, c.g, c.r, idx, code};
        s_tuser <= {fs, req};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task send_pixel(logic [7:0] code, logic fs);
        send_item(REQ_PIXEL, code, 8'($urandom), rgb_t'(24'($urandom)), fs);
    endtask

    task send_entry(logic [7:0] idx, logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fs);
        send_item(REQ_WRITE, 8'($urandom), idx, rgb_t'{r, g, b}, fs);
    endtask

    task send_random_item();
        logic req;
        logic [7:0] code;
        logic [7:0] idx;
        logic fs;
        req = ($urandom_range(99) < 25);
        idx = ($urandom_range(99) < 60) ? 8'($urandom_range(63)) : 8'($urandom);
        if (cur_mode == MODE_HAM6 && $urandom_range(99) < 75) begin
            code = 8'($urandom_range(63));
        end else begin
            code = 8'($urandom);
        end
        fs = ($urandom_range(99) < 5);
        send_item(req, code, idx, rgb_t'(24'($urandom)), fs);
    endtask

    // Drains the block: waits until no expected pixel is pending, then pauses.
    task drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task write_register(logic index, logic [1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task configure(logic [1:0] mode, logic [1:0] ehb_value);
        drain();
        write_register(CFG_COLOR_MODE, mode);
        write_register(CFG_EHB_ENABLE, ehb_value);
        cfg_valid <= 1'b0;
        cur_mode = mode;
    endtask

    logic [1:0] segment_modes [5] = '{MODE_HAM6, MODE_HAM8, MODE_INDEXED, MODE_SPARE, MODE_HAM8};

    initial begin
        aresetn = 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        m_tready <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_COLOR_MODE;
        cfg_data <= '0;
        send_idle_pct = 7;
        recv_idle_pct = 60;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // indexed: cleared palette, extreme entries, frame start on a write
        configure(MODE_INDEXED, 2'd0);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_entry(8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_entry(8'hFF, 8'h80, 8'h01, 8'hFE, 1'b0);
        send_entry(8'hAA, 8'hAA, 8'h55, 8'h00, 1'b0);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'hAA, 1'b0);

        // half-brite copy and writes into the derived region
        configure(MODE_INDEXED, 2'd1);
        send_entry(8'd31, 8'hFF, 8'h81, 8'h02, 1'b0);
        send_entry(8'd40, 8'h12, 8'h34, 8'h56, 1'b0);
        send_pixel(8'd63, 1'b0);
        send_pixel(8'd40, 1'b0);
        send_pixel(8'd31, 1'b0);

        configure(MODE_HAM6, 2'd1);
        send_pixel(8'h00, 1'b1);
        send_pixel(8'h15, 1'b0);
        send_pixel(8'h2A, 1'b0);
        send_pixel(8'h3F, 1'b0);
        send_pixel(8'hC3, 1'b0);
        send_pixel(8'h40, 1'b0);

        configure(MODE_HAM8, 2'd0);
        send_pixel(8'h3F, 1'b0);
        send_pixel(8'h7F, 1'b0);
        send_pixel(8'h81, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'hC0, 1'b1);

        configure(MODE_SPARE, 2'd2);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h00, 1'b1);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 60 : 0;
            recv_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 7 : 0;
            for (int seg = 0; seg < 5; seg++) begin
                configure(segment_modes[seg],
                          {1'($urandom_range(1)), 1'((seg + phase) % 2)});
                repeat (ITEMS_PER_SEGMENT) send_random_item();
            end
        end

        drain();
        if (board.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
